### rtl/cau_pkg.sv
// shared constants, codes, pipeline structs and saturation helper
// for the complex arithmetic unit; no dependencies
`default_nettype none

package cau_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int PORT_W    = 32;
    localparam int PROD_W    = 2 * WORD_BITS;
    localparam int SUM_W     = PROD_W + 1;
    localparam int MAG_W     = 2 * WORD_BITS;
    localparam int REM_W     = 3 * WORD_BITS + FRAC_BITS + 1;
    localparam int Q_W       = WORD_BITS + 1;

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_EQ  = 3'd4;
    localparam logic [2:0] CMD_NE  = 3'd5;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_DZ  = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;

    // sideband that travels with each transaction down the pipe
    typedef struct packed {
        logic                 valid;
        logic                 is_div;
        logic                 dz;
        logic                 neg_re;
        logic                 neg_im;
        logic                 ovf_re;
        logic                 ovf_im;
        logic [WORD_BITS-1:0] re;
        logic [WORD_BITS-1:0] im;
        logic                 flag;
        logic [1:0]           status;
    } t_side;

    // divider lane state handed from cell to cell
    typedef struct packed {
        logic [REM_W-1:0] rem_re;
        logic [REM_W-1:0] rem_im;
        logic [REM_W-1:0] div;
        logic [Q_W-1:0]   q_re;
        logic [Q_W-1:0]   q_im;
    } t_lane;

    // clamp a sign/magnitude value to the word range; top bit flags saturation
    function automatic logic [WORD_BITS:0] sat_word(input logic neg,
                                                    input logic [MAG_W-1:0] mag);
        logic [MAG_W-1:0]     half;
        logic [WORD_BITS-1:0] low;
        logic [WORD_BITS:0]   r;
        half = MAG_W'(1) << (WORD_BITS - 1);
        low  = mag[WORD_BITS-1:0];
        if (!neg && (mag > (half - MAG_W'(1)))) begin
            r = {1'b1, 1'b0, {(WORD_BITS-1){1'b1}}};
        end else if (neg && (mag > half)) begin
            r = {1'b1, 1'b1, {(WORD_BITS-1){1'b0}}};
        end else if (neg) begin
            r = {1'b0, -low};
        end else begin
            r = {1'b0, low};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/cau_front.sv
// front stages: products, add/sub/compare, product sums, divider setup
// depends on cau_pkg
`default_nettype none

module cau_front import cau_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [2:0]        i_command,
    input  wire logic [PORT_W-1:0] i_a_re,
    input  wire logic [PORT_W-1:0] i_a_im,
    input  wire logic [PORT_W-1:0] i_b_re,
    input  wire logic [PORT_W-1:0] i_b_im,
    output t_lane                  o_lane,
    output t_side                  o_side
);

    // stage 1
    logic signed [WORD_BITS-1:0] ar, ai, br, bi;
    logic signed [WORD_BITS:0]   e_re, e_im;
    logic [WORD_BITS:0]          m_re, m_im;
    logic [WORD_BITS:0]          s_re, s_im;
    logic                        eq;
    t_side                       n_s1, r_s1;
    logic signed [PROD_W-1:0]    n_p_rr, n_p_ii, n_p_ri, n_p_ir, n_p_bb_r, n_p_bb_i;
    logic signed [PROD_W-1:0]    r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_p_bb_r, r_p_bb_i;

    assign ar = i_a_re[WORD_BITS-1:0];
    assign ai = i_a_im[WORD_BITS-1:0];
    assign br = i_b_re[WORD_BITS-1:0];
    assign bi = i_b_im[WORD_BITS-1:0];

    always_comb begin
        if (i_command == CMD_SUB) begin
            e_re = (WORD_BITS+1)'(ar) - (WORD_BITS+1)'(br);
            e_im = (WORD_BITS+1)'(ai) - (WORD_BITS+1)'(bi);
        end else begin
            e_re = (WORD_BITS+1)'(ar) + (WORD_BITS+1)'(br);
            e_im = (WORD_BITS+1)'(ai) + (WORD_BITS+1)'(bi);
        end
        m_re = e_re[WORD_BITS] ? -e_re : e_re;
        m_im = e_im[WORD_BITS] ? -e_im : e_im;
        s_re = sat_word(e_re[WORD_BITS], MAG_W'(m_re));
        s_im = sat_word(e_im[WORD_BITS], MAG_W'(m_im));
        eq   = (ar == br) && (ai == bi);

        n_p_rr   = ar * br;
        n_p_ii   = ai * bi;
        n_p_ri   = ar * bi;
        n_p_ir   = ai * br;
        n_p_bb_r = br * br;
        n_p_bb_i = bi * bi;

        n_s1        = '0;
        n_s1.valid  = i_start;
        n_s1.is_div = (i_command == CMD_DIV);
        case (i_command)
            CMD_ADD, CMD_SUB: begin
                n_s1.re     = s_re[WORD_BITS-1:0];
                n_s1.im     = s_im[WORD_BITS-1:0];
                n_s1.status = (s_re[WORD_BITS] || s_im[WORD_BITS]) ? ST_SAT : ST_OK;
            end
            CMD_EQ:  n_s1.flag = eq;
            CMD_NE:  n_s1.flag = !eq;
            default: n_s1.flag = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_p_rr   <= n_p_rr;
        r_p_ii   <= n_p_ii;
        r_p_ri   <= n_p_ri;
        r_p_ir   <= n_p_ir;
        r_p_bb_r <= n_p_bb_r;
        r_p_bb_i <= n_p_bb_i;
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else begin
            r_s1 <= n_s1;
        end
    end

    // stage 2: product sums, multiply result, divider numerators and denominator
    logic signed [SUM_W-1:0] mre, mim, nre, nim;
    logic [MAG_W-1:0]        mre_mag, mim_mag;
    logic [WORD_BITS:0]      ms_re, ms_im;
    logic                    is_mul;
    t_side                   n_s2, r_s2;
    logic [MAG_W-1:0]        n_num_re, n_num_im, n_den;
    logic [MAG_W-1:0]        r_num_re, r_num_im, r_den;
    logic                    r_is_mul;

    always_comb begin
        mre     = SUM_W'(r_p_rr) - SUM_W'(r_p_ii);
        mim     = SUM_W'(r_p_ri) + SUM_W'(r_p_ir);
        nre     = SUM_W'(r_p_rr) + SUM_W'(r_p_ii);
        nim     = SUM_W'(r_p_ir) - SUM_W'(r_p_ri);
        mre_mag = MAG_W'(mre[SUM_W-1] ? -mre : mre);
        mim_mag = MAG_W'(mim[SUM_W-1] ? -mim : mim);
        ms_re   = sat_word(mre[SUM_W-1], mre_mag >> FRAC_BITS);
        ms_im   = sat_word(mim[SUM_W-1], mim_mag >> FRAC_BITS);
        is_mul  = r_is_mul;

        n_s2        = r_s1;
        n_s2.neg_re = nre[SUM_W-1];
        n_s2.neg_im = nim[SUM_W-1];
        if (is_mul) begin
            n_s2.re     = ms_re[WORD_BITS-1:0];
            n_s2.im     = ms_im[WORD_BITS-1:0];
            n_s2.status = (ms_re[WORD_BITS] || ms_im[WORD_BITS]) ? ST_SAT : ST_OK;
        end
        n_num_re = MAG_W'(nre[SUM_W-1] ? -nre : nre);
        n_num_im = MAG_W'(nim[SUM_W-1] ? -nim : nim);
        n_den    = MAG_W'(r_p_bb_r) + MAG_W'(r_p_bb_i);
    end

    always_ff @(posedge i_clk) begin
        r_is_mul <= (i_command == CMD_MUL);
        r_num_re <= n_num_re;
        r_num_im <= n_num_im;
        r_den    <= n_den;
        if (!i_rst_n) begin
            r_s2 <= '0;
        end else begin
            r_s2 <= n_s2;
        end
    end

    // stage 3: scale numerators, align divisor, detect zero divisor and quotient overflow
    t_lane n_lane, r_lane;
    t_side n_s3, r_s3;

    always_comb begin
        n_lane.rem_re = REM_W'(r_num_re) << FRAC_BITS;
        n_lane.rem_im = REM_W'(r_num_im) << FRAC_BITS;
        n_lane.div    = REM_W'(r_den) << WORD_BITS;
        n_lane.q_re   = '0;
        n_lane.q_im   = '0;
        n_s3          = r_s2;
        n_s3.dz       = (r_den == '0);
        n_s3.ovf_re   = n_lane.rem_re >= (n_lane.div << 1);
        n_s3.ovf_im   = n_lane.rem_im >= (n_lane.div << 1);
    end

    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
        if (!i_rst_n) begin
            r_s3 <= '0;
        end else begin
            r_s3 <= n_s3;
        end
    end

    assign o_lane = r_lane;
    assign o_side = r_s3;

endmodule

`default_nettype wire

### rtl/cau_cell.sv
// one restoring divide step for both components, registered
// depends on cau_pkg
`default_nettype none

module cau_cell import cau_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  t_lane      i_lane,
    input  t_side      i_side,
    output t_lane      o_lane,
    output t_side      o_side
);

    t_lane n_lane, r_lane;
    t_side r_side;
    logic  ge_re, ge_im;

    always_comb begin
        ge_re       = i_lane.rem_re >= i_lane.div;
        ge_im       = i_lane.rem_im >= i_lane.div;
        n_lane.rem_re = ge_re ? (i_lane.rem_re - i_lane.div) : i_lane.rem_re;
        n_lane.rem_im = ge_im ? (i_lane.rem_im - i_lane.div) : i_lane.rem_im;
        n_lane.div    = i_lane.div >> 1;
        n_lane.q_re   = {i_lane.q_re[Q_W-2:0], ge_re};
        n_lane.q_im   = {i_lane.q_im[Q_W-2:0], ge_im};
    end

    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
        if (!i_rst_n) begin
            r_side <= '0;
        end else begin
            r_side <= i_side;
        end
    end

    assign o_lane = r_lane;
    assign o_side = r_side;

endmodule

`default_nettype wire

### rtl/complex_arithmetic_unit.sv
// top level of the complex arithmetic unit: front stages, divide cell chain,
// result stage; depends on cau_pkg, cau_front, cau_cell
//
//  channel   handshake          payload
//  command   start / busy       i_command, i_a_re, i_a_im, i_b_re, i_b_im
//  result    o_valid strobe     o_res_re, o_res_im, o_cmp_flag, o_status
//
// fully pipelined: one transaction accepted per cycle, busy stays low
// every command runs through the same path: front stages, divide cell chain, result stage
// the depth is set by the divide chain, one quotient bit per cell
// synchronous active-low reset clears the sideband registers and the valid bit only
// results appear for one cycle with o_valid; the receiver cannot stall
`default_nettype none

module complex_arithmetic_unit import cau_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [2:0]        i_command,
    input  wire logic [PORT_W-1:0] i_a_re,
    input  wire logic [PORT_W-1:0] i_a_im,
    input  wire logic [PORT_W-1:0] i_b_re,
    input  wire logic [PORT_W-1:0] i_b_im,
    output logic                   o_valid,
    output logic [PORT_W-1:0]      o_res_re,
    output logic [PORT_W-1:0]      o_res_im,
    output logic                   o_cmp_flag,
    output logic [1:0]             o_status
);

    // lane/side at each cell boundary of the divide chain
    t_lane w_lane [Q_W+1];
    t_side w_side [Q_W+1];

    // products, add/sub/compare and divider setup
    cau_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_command),
        .i_a_re    (i_a_re),
        .i_a_im    (i_a_im),
        .i_b_re    (i_b_re),
        .i_b_im    (i_b_im),
        .o_lane    (w_lane[0]),
        .o_side    (w_side[0])
    );

    // one cell per quotient bit, msb first
    for (genvar g = 0; g < Q_W; g++) begin : g_cell
        cau_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_lane  (w_lane[g]),
            .i_side  (w_side[g]),
            .o_lane  (w_lane[g+1]),
            .o_side  (w_side[g+1])
        );
    end

    // result stage: divide saturation and zero-divisor handling
    t_lane                last_lane;
    t_side                last_side;
    logic [WORD_BITS:0]   d_re, d_im;
    logic [WORD_BITS-1:0] n_re, n_im;
    logic [1:0]           n_status;
    logic signed [WORD_BITS-1:0] r_re, r_im;
    logic                 r_valid, r_flag;
    logic [1:0]           r_status;

    assign last_lane = w_lane[Q_W];
    assign last_side = w_side[Q_W];

    always_comb begin
        // an overflowed quotient is forced to full scale so it clamps
        d_re     = sat_word(last_side.neg_re,
                            last_side.ovf_re ? {MAG_W{1'b1}} : MAG_W'(last_lane.q_re));
        d_im     = sat_word(last_side.neg_im,
                            last_side.ovf_im ? {MAG_W{1'b1}} : MAG_W'(last_lane.q_im));
        n_re     = last_side.re;
        n_im     = last_side.im;
        n_status = last_side.status;
        if (last_side.is_div) begin
            if (last_side.dz) begin
                n_re     = '0;
                n_im     = '0;
                n_status = ST_DZ;
            end else begin
                n_re     = d_re[WORD_BITS-1:0];
                n_im     = d_im[WORD_BITS-1:0];
                n_status = (d_re[WORD_BITS] || d_im[WORD_BITS]) ? ST_SAT : ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_re     <= n_re;
        r_im     <= n_im;
        r_flag   <= last_side.flag;
        r_status <= n_status;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= last_side.valid;
        end
    end

    // never stalls; a transaction enters every cycle start is high
    assign busy       = 1'b0;
    assign o_valid    = r_valid;
    assign o_res_re   = PORT_W'(r_re);
    assign o_res_im   = PORT_W'(r_im);
    assign o_cmp_flag = r_flag;
    assign o_status   = r_status;

endmodule

`default_nettype wire
